// ===== rtl/core/hgp_pkg.sv =====
// Package with shared types and constants of the HTTP GET request-line parser.
`timescale 1ns / 1ps
`default_nettype none

package hgp_pkg;

  localparam int DEF_LINE_CAPACITY = 255;
  localparam int DEF_CHUNK_BYTES   = 8;
  localparam int MAX_RESULTS       = 32;
  localparam int SUFFIX_LEN        = 9;

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_LF     = 8'd10;
  localparam logic [7:0] CHAR_NUL    = 8'd0;
  localparam logic [7:0] CHAR_SLASH  = 8'h2F;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;

  localparam logic [7:0] GET_WORD [4] = '{8'h47, 8'h45, 8'h54, 8'h20};
  localparam logic [7:0] END_WORD [4] = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

  // The oldest byte of the tail window sits in the lowest octet, so the
  // leading space of the suffix is the least significant byte here.
  localparam logic [8*SUFFIX_LEN-1:0] SUFFIX_WORD = "1.1/PTTH ";

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LINE,
    PH_HEAD
  } phase_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_CHECK,
    ST_READ,
    ST_PUSH
  } seq_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/hgp_if.sv =====
// Stream interfaces for request bytes and reply chunks.
`timescale 1ns / 1ps
`default_nettype none

interface hgp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface hgp_reply_if;
  logic        valid;
  logic        ready;
  logic        reply_kind;
  logic [63:0] chunk_bytes;
  logic [3:0]  chunk_count;
  logic        last_chunk;

  modport source (output valid, output reply_kind, output chunk_bytes,
                  output chunk_count, output last_chunk, input ready);
  modport sink (input valid, input reply_kind, input chunk_bytes,
                input chunk_count, input last_chunk, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/http_get_request_parser.sv =====
// Top level of the HTTP GET request-line parser with its line store and read-out sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one request byte per cycle while the parser runs; ready is low otherwise.
// After the final LF of CR LF CR LF the line is checked; each filename chunk is then read
// byte by byte through the single line-store read port and pushed, and the push waits
// while the reply side stalls. A not-found reply takes the check and a single push.
// Reset (rst, synchronous, active high) restarts the hunt for "GET " and empties the
// reply register; the line store itself is not cleared and needs no clearing pass.

module http_get_request_parser
  import hgp_pkg::*;
#(
  parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
  parameter int CHUNK_BYTES   = DEF_CHUNK_BYTES
) (
  input  wire          clk,
  input  wire          rst,
  hgp_byte_if.sink     req,
  hgp_reply_if.source  reply
);

  // Position counters must hold the capacity itself; store indexes only reach below it.
  localparam int LEN_W    = $clog2(LINE_CAPACITY + 1);
  localparam int ADDR_W   = $clog2(LINE_CAPACITY);
  localparam int MAX_NAME = MAX_RESULTS * CHUNK_BYTES;
  localparam int REM_W    = $clog2(MAX_NAME + 1);
  localparam int SPAN_W   = (LEN_W > REM_W) ? LEN_W : REM_W;
  localparam int FILL_W   = $clog2(CHUNK_BYTES + 1);
  localparam int ACC_W    = 8 * CHUNK_BYTES;
  localparam int TAIL_W   = 8 * SUFFIX_LEN;

  // Parser state.
  seq_state_t        state, state_next;
  phase_t            phase, phase_next;
  logic [1:0]        match_count, match_count_next;
  logic [LEN_W-1:0]  line_length, line_length_next;
  logic              last_sep_valid, last_sep_valid_next;
  logic [LEN_W-1:0]  last_sep_pos, last_sep_pos_next;
  logic              prior_sep_valid, prior_sep_valid_next;
  logic [LEN_W-1:0]  prior_sep_pos, prior_sep_pos_next;
  logic [TAIL_W-1:0] tail_window, tail_window_next;

  // Read-out sequencer state.
  logic [LEN_W-1:0]  rd_addr, rd_addr_next;
  logic [REM_W-1:0]  remain, remain_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [FILL_W-1:0] fill, fill_next;
  logic              not_found, not_found_next;

  // Reply register; it parts the reply side from the parser.
  logic              out_valid, out_valid_next;
  logic              out_kind, out_kind_next;
  logic [63:0]       out_bytes, out_bytes_next;
  logic [3:0]        out_count, out_count_next;
  logic              out_last, out_last_next;

  // Line store: one write port used while parsing, one registered read port used
  // while chunks are read out.
  logic [7:0]        line_mem [LINE_CAPACITY];
  logic              mem_we;
  logic [7:0]        rd_data;

  assign req.ready         = (state == ST_RUN);
  assign reply.valid       = out_valid;
  assign reply.reply_kind  = out_kind;
  assign reply.chunk_bytes = out_bytes;
  assign reply.chunk_count = out_count;
  assign reply.last_chunk  = out_last;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[line_length[ADDR_W-1:0]] <= req.data_byte;
    end
    // The read address is the one the sequencer will hold next cycle, so rd_data
    // always matches rd_addr while reading out.
    rd_data <= line_mem[rd_addr_next[ADDR_W-1:0]];
  end

  always_comb begin
    logic [7:0]        b;
    logic              is_eol;
    logic              is_sep;
    logic              fits;
    logic              suffix_ok;
    logic [LEN_W-1:0]  name_end;
    logic [LEN_W-1:0]  start_pos;
    logic [SPAN_W-1:0] span;
    logic              out_free;
    logic              final_push;

    state_next           = state;
    phase_next           = phase;
    match_count_next     = match_count;
    line_length_next     = line_length;
    last_sep_valid_next  = last_sep_valid;
    last_sep_pos_next    = last_sep_pos;
    prior_sep_valid_next = prior_sep_valid;
    prior_sep_pos_next   = prior_sep_pos;
    tail_window_next     = tail_window;
    rd_addr_next         = rd_addr;
    remain_next          = remain;
    acc_next             = acc;
    fill_next            = fill;
    not_found_next       = not_found;
    out_valid_next       = out_valid;
    out_kind_next        = out_kind;
    out_bytes_next       = out_bytes;
    out_count_next       = out_count;
    out_last_next        = out_last;
    mem_we               = 1'b0;

    b          = req.data_byte;
    is_eol     = (b == CHAR_CR) || (b == CHAR_LF);
    is_sep     = (b == CHAR_SLASH) || (b == CHAR_BSLASH);
    fits       = (line_length < LEN_W'(LINE_CAPACITY));
    suffix_ok  = (line_length >= LEN_W'(SUFFIX_LEN)) && (tail_window == SUFFIX_WORD);
    name_end   = line_length - LEN_W'(SUFFIX_LEN);
    start_pos  = prior_sep_valid ? (prior_sep_pos + LEN_W'(1)) : '0;
    span       = SPAN_W'(name_end) - SPAN_W'(start_pos);
    out_free   = !out_valid || reply.ready;
    final_push = not_found || (remain == '0);

    if (out_valid && reply.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_RUN: begin
        if (req.valid) begin
          if (phase == PH_LINE) begin
            if (is_eol) begin
              phase_next = PH_HEAD;
            end else if (b != CHAR_NUL) begin
              if (fits) begin
                mem_we           = 1'b1;
                line_length_next = line_length + LEN_W'(1);
                tail_window_next = {b, tail_window[TAIL_W-1:8]};
                if (is_sep) begin
                  prior_sep_valid_next = last_sep_valid;
                  prior_sep_pos_next   = last_sep_pos;
                  last_sep_valid_next  = 1'b1;
                  last_sep_pos_next    = line_length;
                end
              end else begin
                // Overflow: the request is dropped and the hunt starts over.
                phase_next           = PH_HUNT;
                match_count_next     = '0;
                line_length_next     = '0;
                last_sep_valid_next  = 1'b0;
                prior_sep_valid_next = 1'b0;
                tail_window_next     = '0;
              end
            end
          end else if (phase == PH_HUNT) begin
            // A byte that breaks the match is not retried as a first letter.
            if (b == GET_WORD[match_count]) begin
              if (match_count == 2'd3) begin
                phase_next       = PH_LINE;
                match_count_next = '0;
              end else begin
                match_count_next = match_count + 2'd1;
              end
            end else begin
              match_count_next = '0;
            end
          end

          // End-of-headers tracking runs on the same byte once inside a request.
          if ((phase_next == PH_LINE) || (phase_next == PH_HEAD)) begin
            if (b == END_WORD[match_count_next]) begin
              if (match_count_next == 2'd3) begin
                phase_next       = PH_HUNT;
                match_count_next = '0;
                state_next       = ST_CHECK;
              end else begin
                match_count_next = match_count_next + 2'd1;
              end
            end else begin
              match_count_next = '0;
            end
          end
        end
      end

      ST_CHECK: begin
        // The last separator is the slash inside the suffix, so the one before
        // it marks where the filename begins.
        if (!suffix_ok) begin
          state_next = ST_RUN;
        end else if (start_pos >= name_end) begin
          not_found_next = 1'b1;
          acc_next       = '0;
          fill_next      = '0;
          state_next     = ST_PUSH;
        end else begin
          remain_next  = (span > SPAN_W'(MAX_NAME)) ? REM_W'(MAX_NAME) : REM_W'(span);
          rd_addr_next = start_pos;
          state_next   = ST_READ;
        end
        line_length_next     = '0;
        last_sep_valid_next  = 1'b0;
        prior_sep_valid_next = 1'b0;
        tail_window_next     = '0;
      end

      ST_READ: begin
        for (int k = 0; k < CHUNK_BYTES; k++) begin
          if (fill == FILL_W'(k)) begin
            acc_next[8*k +: 8] = rd_data;
          end
        end
        fill_next    = fill + FILL_W'(1);
        remain_next  = remain - REM_W'(1);
        rd_addr_next = rd_addr + LEN_W'(1);
        if ((fill_next == FILL_W'(CHUNK_BYTES)) || (remain == REM_W'(1))) begin
          state_next = ST_PUSH;
        end
      end

      ST_PUSH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          out_kind_next  = not_found;
          out_bytes_next = 64'(acc);
          out_count_next = 4'(fill);
          out_last_next  = final_push;
          acc_next       = '0;
          fill_next      = '0;
          not_found_next = 1'b0;
          state_next     = final_push ? ST_RUN : ST_READ;
        end
      end

      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_RUN;
      phase           <= PH_HUNT;
      match_count     <= '0;
      line_length     <= '0;
      last_sep_valid  <= 1'b0;
      prior_sep_valid <= 1'b0;
      tail_window     <= '0;
      rd_addr         <= '0;
      remain          <= '0;
      acc             <= '0;
      fill            <= '0;
      not_found       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      phase           <= phase_next;
      match_count     <= match_count_next;
      line_length     <= line_length_next;
      last_sep_valid  <= last_sep_valid_next;
      prior_sep_valid <= prior_sep_valid_next;
      tail_window     <= tail_window_next;
      rd_addr         <= rd_addr_next;
      remain          <= remain_next;
      acc             <= acc_next;
      fill            <= fill_next;
      not_found       <= not_found_next;
      out_valid       <= out_valid_next;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    last_sep_pos  <= last_sep_pos_next;
    prior_sep_pos <= prior_sep_pos_next;
    out_kind      <= out_kind_next;
    out_bytes     <= out_bytes_next;
    out_count     <= out_count_next;
    out_last      <= out_last_next;
  end

endmodule

`default_nettype wire

// ===== tb/hgp_reply_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the reply chunks of the request-line parser.
`timescale 1ns / 1ps

package hgp_reply_scoreboard_pkg;
  import hgp_pkg::*;

  typedef struct packed {
    logic        reply_kind;
    logic [63:0] chunk_bytes;
    logic [3:0]  chunk_count;
    logic        last_chunk;
  } reply_t;

  class reply_scoreboard;
    phase_t                  phase;
    int                      match_cnt;
    int                      line_len;
    logic [7:0]              line_buf [DEF_LINE_CAPACITY];
    bit                      last_sep_ok;
    int                      last_sep_at;
    bit                      prior_sep_ok;
    int                      prior_sep_at;
    logic [8*SUFFIX_LEN-1:0] tail;
    reply_t                  pending_replies[$];
    int                      expected_total;
    int                      checked;
    int                      not_found_seen;
    int                      final_seen;
    int                      errors;

    function new();
      phase          = PH_HUNT;
      match_cnt      = 0;
      expected_total = 0;
      checked        = 0;
      not_found_seen = 0;
      final_seen     = 0;
      errors         = 0;
      clear_line();
    endfunction

    function void clear_line();
      line_len     = 0;
      last_sep_ok  = 1'b0;
      last_sep_at  = 0;
      prior_sep_ok = 1'b0;
      prior_sep_at = 0;
      tail         = '0;
    endfunction

    // Advances the parser state by one accepted byte and queues any replies it causes.
    function void note_byte(logic [7:0] b);
      int          name_end;
      int          start;
      int          n;
      int          take;
      logic [63:0] word;
      reply_t      r;
      if (phase == PH_LINE) begin
        if (b == CHAR_CR || b == CHAR_LF) begin
          phase = PH_HEAD;
        end else if (b != CHAR_NUL) begin
          if (line_len < DEF_LINE_CAPACITY) begin
            line_buf[line_len] = b;
            if (b == CHAR_SLASH || b == CHAR_BSLASH) begin
              prior_sep_ok = last_sep_ok;
              prior_sep_at = last_sep_at;
              last_sep_ok  = 1'b1;
              last_sep_at  = line_len;
            end
            tail = {b, tail[8*SUFFIX_LEN-1:8]};
            line_len++;
          end else begin
            phase     = PH_HUNT;
            match_cnt = 0;
            clear_line();
          end
        end
      end else if (phase != PH_HEAD) begin
        if (b == GET_WORD[match_cnt]) begin
          match_cnt++;
          if (match_cnt == 4) begin
            phase     = PH_LINE;
            match_cnt = 0;
          end
        end else begin
          match_cnt = 0;
        end
      end

      if (phase == PH_LINE || phase == PH_HEAD) begin
        if (b == END_WORD[match_cnt]) begin
          match_cnt++;
          if (match_cnt == 4) begin
            phase     = PH_HUNT;
            match_cnt = 0;
            if (line_len >= SUFFIX_LEN && tail == SUFFIX_WORD) begin
              name_end = line_len - SUFFIX_LEN;
              // The last separator is the slash inside the suffix, so the one before counts.
              start = prior_sep_ok ? prior_sep_at + 1 : 0;
              if (start >= name_end) begin
                r = '{reply_kind: 1'b1, chunk_bytes: '0, chunk_count: '0, last_chunk: 1'b1};
                pending_replies.push_back(r);
                expected_total++;
              end else begin
                n = name_end - start;
                if (n > MAX_RESULTS * DEF_CHUNK_BYTES) n = MAX_RESULTS * DEF_CHUNK_BYTES;
                for (int i = 0; i < n; i += DEF_CHUNK_BYTES) begin
                  take = (n - i < DEF_CHUNK_BYTES) ? n - i : DEF_CHUNK_BYTES;
                  word = '0;
                  for (int j = 0; j < take; j++) word[8*j +: 8] = line_buf[start + i + j];
                  r.reply_kind  = 1'b0;
                  r.chunk_bytes = word;
                  r.chunk_count = 4'(take);
                  r.last_chunk  = (i + take >= n);
                  pending_replies.push_back(r);
                  expected_total++;
                end
              end
            end
            clear_line();
          end
        end else begin
          match_cnt = 0;
        end
      end
    endfunction

    // Compares one accepted reply with the oldest outstanding prediction.
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected reply: reply_kind %0d chunk_bytes %h chunk_count %0d last_chunk %0d",
               got.reply_kind, got.chunk_bytes, got.chunk_count, got.last_chunk);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      checked++;
      if (want.reply_kind) not_found_seen++;
      if (want.last_chunk) final_seen++;
      if (got.reply_kind !== want.reply_kind) begin
        $error("reply_kind: expected %0d, actual %0d", want.reply_kind, got.reply_kind);
        errors++;
      end
      if (got.chunk_bytes !== want.chunk_bytes) begin
        $error("chunk_bytes: expected %h, actual %h", want.chunk_bytes, got.chunk_bytes);
        errors++;
      end
      if (got.chunk_count !== want.chunk_count) begin
        $error("chunk_count: expected %0d, actual %0d", want.chunk_count, got.chunk_count);
        errors++;
      end
      if (got.last_chunk !== want.last_chunk) begin
        $error("last_chunk: expected %0d, actual %0d", want.last_chunk, got.last_chunk);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/http_get_request_parser_tb.sv =====
// Top-level testbench of the HTTP GET request-line parser.
`timescale 1ns / 1ps

module http_get_request_parser_tb;
  import hgp_pkg::*;
  import hgp_reply_scoreboard_pkg::*;

  // A run is declared hung when the count of cycles in which neither side completes
  // a transaction reaches this limit. The slowest legal gap is a long receiver stall
  // on top of one chunk read-out.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last expected reply, to catch any stray extra reply.
  localparam int DRAIN_CYCLES   = 60;
  localparam int RANDOM_BYTES   = 130;

  logic clk;
  logic rst;

  hgp_byte_if  req_if ();
  hgp_reply_if reply_if ();

  http_get_request_parser u_dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req_if),
    .reply (reply_if)
  );

  reply_scoreboard sb = new();

  // When calm is set both sides stop idling, so back-to-back transactions get exercised.
  bit         calm;
  logic [7:0] tx_bytes[$];
  int         bytes_sent;
  int         requests_sent;
  int         stall_cycles;
  reply_t     seen_reply;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none or a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) tx_bytes.push_back(s[i]);
  endfunction

  function automatic void add_line_break();
    tx_bytes.push_back(CHAR_CR);
    tx_bytes.push_back(CHAR_LF);
  endfunction

  // Path bytes lean on separators and zero bytes, and leave room for any octet
  // except CR and LF, which would end the line early.
  function automatic logic [7:0] path_char();
    int         r;
    logic [7:0] v;
    r = $urandom_range(0, 99);
    if (r < 12) return CHAR_SLASH;
    if (r < 18) return CHAR_BSLASH;
    if (r < 21) return CHAR_NUL;
    if (r < 33) begin
      v = 8'($urandom_range(0, 255));
      if (v == CHAR_CR || v == CHAR_LF) v = v ^ 8'h80;
      return v;
    end
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  // Builds one random request. Most are well formed with random paths and
  // headers; the rest are line noise, broken prefixes, wrong suffixes,
  // oversized lines and requests cut off before the end of the headers.
  function automatic void add_random_request();
    int pick;
    int path_len;
    int headers;
    bit lf_only;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 40)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 19))
      0: add_text("GE");
      1: add_text("GGET ");
      2: add_text("get ");
      default: add_text("GET ");
    endcase
    path_len = ($urandom_range(0, 99) < 8) ? $urandom_range(200, 260) : $urandom_range(0, 24);
    repeat (path_len) tx_bytes.push_back(path_char());
    if ($urandom_range(0, 99) < 6) return;
    case ($urandom_range(0, 19))
      0: add_text(" HTTP/1.0");
      1: add_text("HTTP/1.1");
      2: add_text(" HTTP/1.");
      default: add_text(" HTTP/1.1");
    endcase
    // A bare LF also ends the line, but the end of headers still needs CR LF CR LF.
    lf_only = ($urandom_range(0, 4) == 0);
    if (!lf_only) tx_bytes.push_back(CHAR_CR);
    tx_bytes.push_back(CHAR_LF);
    headers = $urandom_range(0, 3);
    repeat (headers) begin
      repeat ($urandom_range(1, 20)) tx_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      add_line_break();
    end
    add_line_break();
    if (lf_only && headers == 0) add_line_break();
  endfunction

  // Offers one byte and waits for the transaction. Valid stays high into the
  // next byte when no gap is drawn, so only one assignment lands per edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.data_byte <= b;
    @(posedge clk);
    while (!(req_if.valid && req_if.ready)) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front());
    requests_sent++;
  endtask

  // The receiver holds ready high for a random run, then drops it for a gap.
  initial begin
    int gap;
    reply_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      reply_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        reply_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Monitor: values read at the edge are the ones the block itself sampled,
  // since every output and every driven input changes only in the NBA region.
  always @(posedge clk) begin
    if (!rst) begin
      if (reply_if.valid && reply_if.ready) begin
        seen_reply.reply_kind  = reply_if.reply_kind;
        seen_reply.chunk_bytes = reply_if.chunk_bytes;
        seen_reply.chunk_count = reply_if.chunk_count;
        seen_reply.last_chunk  = reply_if.last_chunk;
        sb.check_reply(seen_reply);
      end
      if (req_if.valid && req_if.ready) sb.note_byte(req_if.data_byte);
    end
  end

  // Watchdog: any completed transaction on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (reply_if.valid && reply_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired: no transaction for %0d cycles, %0d replies outstanding.",
                 WATCHDOG_LIMIT, sb.pending_replies.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int directed_bytes;
    rst              <= 1'b1;
    req_if.valid     <= 1'b0;
    req_if.data_byte <= 8'h00;
    calm          = 1'b0;
    bytes_sent    = 0;
    requests_sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part. A plain file in a directory, with one header line.
    add_text("GET /index.html HTTP/1.1");
    add_line_break();
    add_text("Host: x");
    add_line_break();
    add_line_break();
    send_queued();

    // A path that ends in a separator asks for a directory: one not-found reply.
    add_text("GET /dir/sub/ HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // Without any separator the whole line in front of the suffix is the filename.
    add_text("GET name.txt HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // Backslash separators, and a bare LF closing the request line.
    add_text("GET \\a\\b.c HTTP/1.1");
    tx_bytes.push_back(CHAR_LF);
    add_line_break();
    add_line_break();
    send_queued();

    // A line shorter than the suffix gives nothing; a line that is only the
    // suffix has an empty filename and gives a not-found reply.
    add_text("GET HTTP/1.1");
    add_line_break();
    add_line_break();
    add_text("GET  HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // Wrong protocol version, then two broken GET prefixes; none of them replies.
    add_text("GET /a HTTP/1.0");
    add_line_break();
    add_line_break();
    add_text("GGET /x HTTP/1.1");
    add_line_break();
    add_line_break();
    add_text("GEGET /y HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // Zero bytes inside the line are dropped; mixed separators pick the last one.
    add_text("GET /");
    tx_bytes.push_back(CHAR_NUL);
    add_text("ab");
    tx_bytes.push_back(CHAR_NUL);
    add_text("c HTTP/1.1");
    add_line_break();
    add_line_break();
    add_text("GET /a\\b/c HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // A full chunk of extreme octets.
    add_text("GET /");
    tx_bytes.push_back(8'hFF);
    tx_bytes.push_back(8'h80);
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(8'h7F);
    tx_bytes.push_back(8'hFE);
    tx_bytes.push_back(8'hAA);
    tx_bytes.push_back(8'h55);
    tx_bytes.push_back(8'hC3);
    add_text(" HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // A line of exactly the store's capacity: the longest filename the block can serve.
    add_text("GET ");
    repeat (DEF_LINE_CAPACITY - SUFFIX_LEN) tx_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
    add_text(" HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    // One byte past capacity abandons the request; the rest is hunted over,
    // and the following request must be served normally.
    add_text("GET ");
    repeat (DEF_LINE_CAPACITY + 1) tx_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
    add_text(" HTTP/1.1");
    add_line_break();
    add_line_break();
    add_text("GET /ok HTTP/1.1");
    add_line_break();
    add_line_break();
    send_queued();

    directed_bytes = bytes_sent;

    // Random part: runs until enough bytes have gone in.
    while (bytes_sent - directed_bytes < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      add_random_request();
      send_queued();
    end
    req_if.valid <= 1'b0;
    calm = 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d request bytes in %0d request sequences, directed and random.",
             bytes_sent, requests_sent);
    $display("Checked %0d replies: %0d not-found, %0d request endings, %0d mismatches.",
             sb.checked, sb.not_found_seen, sb.final_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
